// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held
`define LBP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset
`define LBP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lbp_pkg.sv =====
// Package: types and constants of the LSB-first bit packer
`timescale 1ns / 1ps
package lbp_pkg;

    localparam int LBP_MAX_WIDTH   = 32;
    localparam int LBP_COUNT_BITS  = 32;
    localparam int LBP_QUEUE_DEPTH = 4;

    typedef enum logic {
        OP_SHOVE = 1'b0,
        OP_FLUSH = 1'b1
    } t_opcode;

    // One queued job: up to four bytes to emit, lowest byte first
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        present;
    } t_lbp_entry;

endpackage

// ===== rtl/core/lbp_front.sv =====
// Front end: merges incoming codes with the partial byte and queues whole bytes
`timescale 1ns / 1ps
module lbp_front #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_opcode,
    input  logic [5:0]          i_width,
    input  logic [31:0]         i_value,
    input  logic                i_full,
    output logic                o_push,
    output lbp_pkg::t_lbp_entry o_entry
);
    import lbp_pkg::*;

    logic [2:0]  r_pend;
    logic [7:0]  r_part;
    logic [2:0]  n_pend;
    logic [7:0]  n_part;
    logic [5:0]  w_sat;
    logic [32:0] mask33;
    logic [31:0] val_m;
    logic [39:0] acc;
    logic [5:0]  total;
    logic [2:0]  nb;
    logic        accept;
    logic        is_flush;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign is_flush = (t_opcode'(i_opcode) == OP_FLUSH);

    always_comb begin
        w_sat  = (i_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : i_width;
        mask33 = (33'd1 << w_sat) - 33'd1;
        val_m  = i_value & mask33[31:0];
        acc    = (40'(val_m) << r_pend) | 40'(r_part);
        total  = 6'(r_pend) + w_sat;
        nb     = total[5:3];
    end

    always_comb begin
        o_entry = '0;
        n_pend  = r_pend;
        n_part  = r_part;
        if (is_flush) begin
            o_entry.data    = 32'(r_part);
            o_entry.nbytes  = 3'd1;
            o_entry.present = (r_pend != 3'd0);
            n_pend          = 3'd0;
            n_part          = 8'd0;
        end else begin
            o_entry.data    = acc[31:0];
            o_entry.nbytes  = nb;
            o_entry.present = 1'b1;
            n_pend          = total[2:0];
            case (nb)
                3'd0:    n_part = acc[7:0];
                3'd1:    n_part = acc[15:8];
                3'd2:    n_part = acc[23:16];
                3'd3:    n_part = acc[31:24];
                3'd4:    n_part = acc[39:32];
                default: n_part = acc[7:0];
            endcase
        end
    end

    // A shove that completes no byte queues nothing
    assign o_push = accept && (is_flush || (nb != 3'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 3'd0;
            r_part <= 8'd0;
        end else if (accept) begin
            r_pend <= n_pend;
            r_part <= n_part;
        end
    end

endmodule

// ===== rtl/core/lbp_queue.sv =====
// Short job queue between front and back end
`timescale 1ns / 1ps
module lbp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lbp_pkg::t_lbp_entry i_entry,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output lbp_pkg::t_lbp_entry o_head
);
    import lbp_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_lbp_entry          r_mem [DEPTH];
    logic [PTR_BITS:0]   r_wr;
    logic [PTR_BITS:0]   r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[PTR_BITS] != r_rd[PTR_BITS]) &&
                     (r_wr[PTR_BITS-1:0] == r_rd[PTR_BITS-1:0]);
    assign o_head  = r_mem[r_rd[PTR_BITS-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[PTR_BITS-1:0]] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/lbp_back.sv =====
// Back end: emits queued bytes one per cycle unless stalled, and keeps the byte count
`timescale 1ns / 1ps
module lbp_back #(
    parameter int COUNT_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  lbp_pkg::t_lbp_entry i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_byte,
    output logic                o_present,
    output logic                o_last,
    output logic [31:0]         o_count
);
    import lbp_pkg::*;

    logic                  r_valid;
    logic [1:0]            r_idx;
    logic [COUNT_BITS-1:0] r_total;
    logic [7:0]            r_byte;
    logic                  r_present;
    logic                  r_last;
    logic [31:0]           r_count;
    logic [COUNT_BITS-1:0] n_total;
    logic [63:0]           total_ext;
    logic [7:0]            sel_byte;
    logic                  load;
    logic                  take;
    logic                  is_last;

    assign load    = !r_valid || i_ready;
    assign take    = load && !i_empty;
    assign is_last = ({1'b0, r_idx} == (i_head.nbytes - 3'd1));
    assign o_pop   = take && is_last;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.data[7:0];
            2'd1:    sel_byte = i_head.data[15:8];
            2'd2:    sel_byte = i_head.data[23:16];
            2'd3:    sel_byte = i_head.data[31:24];
            default: sel_byte = i_head.data[7:0];
        endcase
        n_total   = r_total + COUNT_BITS'(i_head.present);
        total_ext = 64'(n_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
            r_total <= '0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (take) begin
                r_total <= n_total;
                r_idx   <= is_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte    <= i_head.present ? sel_byte : 8'd0;
            r_present <= i_head.present;
            r_last    <= is_last;
            r_count   <= total_ext[31:0];
        end
    end

    assign o_valid   = r_valid;
    assign o_byte    = r_byte;
    assign o_present = r_present;
    assign o_last    = r_last;
    assign o_count   = r_count;

endmodule

// ===== rtl/core/lsb_first_bit_packer_unit.sv =====
// Top level of the LSB-first bit packer
`timescale 1ns / 1ps
// Packs variable-width codes into a byte stream, least significant bit first.
// Input channel (s_axis): tuser carries the opcode (shove or flush), tdata the
// width (0..32, larger values saturate to MAX_WIDTH) and the code value. A shove
// appends the low width bits to the pending partial byte; each byte that fills
// up leaves as one item, so a shove gives zero to four items. A flush pads the
// partial byte with zeros and always gives exactly one item; with nothing
// pending that item has tuser low and only carries the byte count.
// Output channel (m_axis): tdata holds the byte and the running count of bytes
// written, tuser says a byte is present, tlast marks the last item of an input.
// The first item of an input passes through the job queue and then the back-end
// output register. Throughput: one output item per cycle while the receiver is
// ready, set by the single output register in the back end. The front end
// takes a new item every cycle while the four-entry job queue has room.
// Reset clears the partial byte, the byte count and the queue.
// When the receiver stalls the output item holds, the queue fills and then
// s_axis_tready drops; nothing is dropped.
module lsb_first_bit_packer_unit #(
    parameter int MAX_WIDTH  = lbp_pkg::LBP_MAX_WIDTH,
    parameter int COUNT_BITS = lbp_pkg::LBP_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [5:0] field_width, [37:6] field_value, zero pad
    input  logic        s_axis_tuser,  // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [7:0] out_byte, [39:8] bytes_written
    output logic        m_axis_tuser,  // [0] byte_present
    output logic        m_axis_tlast   // last_of_run
);
    import lbp_pkg::*;

    t_lbp_entry push_entry;
    t_lbp_entry head_entry;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic [31:0] out_count;

    // Classify and merge codes with the partial byte
    lbp_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_opcode (s_axis_tuser),
        .i_width  (s_axis_tdata[5:0]),
        .i_value  (s_axis_tdata[37:6]),
        .i_full   (full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    // Hold completed jobs until the back end drains them
    lbp_queue #(
        .DEPTH (LBP_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head_entry)
    );

    // Emit one byte per cycle unless stalled, and advance the count
    lbp_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_head    (head_entry),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (out_byte),
        .o_present (m_axis_tuser),
        .o_last    (m_axis_tlast),
        .o_count   (out_count)
    );

    assign m_axis_tdata = {out_count, out_byte};

endmodule

// ===== rtl/core/lbp_checker.sv =====
// Port-level checker for the bit packer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lbp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled output item holds
    `LBP_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output item changed while stalled")

    // A count-only result always ends its run
    `LBP_ASSERT(a_count_only_last, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast, "count-only result without tlast")

    // Within a run, the next byte follows at once and the count steps by one
    `LBP_ASSERT(a_run_count, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tuser && !m_axis_tlast |=> m_axis_tvalid && m_axis_tuser && (m_axis_tdata[39:8] == $past(m_axis_tdata[39:8]) + 32'd1), "byte count broke within a run")

    // Nothing is offered right after reset
    `LBP_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind lsb_first_bit_packer_unit lbp_checker u_lbp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
